// ===== hw/rtl/log_ftl_fifo_cleaner_core_assert.svh =====
// assertion helpers for the log ftl cleaner core
`ifndef LOG_FTL_FIFO_CLEANER_CORE_ASSERT_SVH
`define LOG_FTL_FIFO_CLEANER_CORE_ASSERT_SVH

// same-cycle implication
`define LFC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfc assertion failed");

// next-cycle implication
`define LFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfc assertion failed");

`endif

// ===== hw/rtl/lfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfc_pkg;

   localparam int PHYS_AW = 12;
   localparam logic [12:0] MAX_PHYS_PAGES = 13'd4096;
   localparam logic [6:0] MAX_PAGES_PER_BLOCK = 7'd64;
   localparam logic [12:0] P2L_INVALID = 13'h1FFF;

   localparam logic [12:0] RST_TOTAL_BLOCKS = 13'd64;
   localparam logic [11:0] RST_USER_BLOCKS = 12'd48;
   localparam logic [6:0] RST_PAGES_PER_BLOCK = 7'd64;

   localparam logic [1:0] CSR_TOTAL_BLOCKS = 2'd0;
   localparam logic [1:0] CSR_USER_BLOCKS = 2'd1;
   localparam logic [1:0] CSR_PAGES_PER_BLOCK = 2'd2;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_FORMAT = 2'd2;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_LPAGE_RANGE = 2'd1;
   localparam logic [1:0] STS_LOOKUP_RANGE = 2'd2;
   localparam logic [1:0] STS_BAD_CONFIG = 2'd3;

   typedef struct packed {
      logic p2l_we;
      logic [PHYS_AW-1:0] p2l_waddr;
      logic [12:0] p2l_wdata;
      logic [PHYS_AW-1:0] p2l_raddr;
      logic l2p_we;
      logic [PHYS_AW-1:0] l2p_waddr;
      logic [11:0] l2p_wdata;
      logic [PHYS_AW-1:0] l2p_raddr;
   } map_cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lfc_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfc_mac (
   input wire logic clock,
   input wire logic [12:0] mul_a,
   input wire logic [6:0] mul_b,
   input wire logic [6:0] add_c,
   output logic [19:0] res_ff
);
   // shared multiply-add, one registered result per cycle
   always_ff @(posedge clock) begin
      res_ff <= 20'(mul_a) * 20'(mul_b) + 20'(add_c);
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lfc_maps.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfc_maps (
   input wire logic clock,
   input wire lfc_pkg::map_cmd_type cmd,
   output logic [12:0] p2l_rd_ff,
   output logic [11:0] l2p_rd_ff
);
   import lfc_pkg::*;

   localparam int DEPTH = 1 << PHYS_AW;

   logic [12:0] p2l_mem [DEPTH];
   logic [11:0] l2p_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.p2l_we) begin
         p2l_mem[cmd.p2l_waddr] <= cmd.p2l_wdata;
      end
      p2l_rd_ff <= p2l_mem[cmd.p2l_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.l2p_we) begin
         l2p_mem[cmd.l2p_waddr] <= cmd.l2p_wdata;
      end
      l2p_rd_ff <= l2p_mem[cmd.l2p_raddr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/log_ftl_fifo_cleaner_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// page-mapped flash translation layer over a circular log, fifo cleaning
// req channel: one beat per command (host write, physical lookup, format)
// rsp channel: exactly one beat per request beat, in order
// csr port: writes total_blocks, user_blocks, pages_per_block; the values
//   take effect only at the next format command
// a host write first cleans whole blocks at the tail, moving each valid page
//   to the head, until two blocks of pages are free or every block was cleaned;
//   lookup reads the map; format checks the geometry, then sweeps every page
// the next request beat can be taken once the result is loaded into the output register
// the sequencer drives one shared multiply-add unit and two map memories
//   (one write and one read per memory per cycle)
// one command is worked at a time; req_tready is high only while idle
// reset loads the default geometry and sweeps the maps, one page per cycle,
//   over all total_blocks * pages_per_block = 4096 pages, before the first beat
// a stalled rsp beat holds in the output register; the next request is
//   still taken and its result waits until the register frees
module log_ftl_fifo_cleaner_core (
   input wire logic clock,
   input wire logic reset,
   // cmd[1:0], logical_page[13:2], block_index[25:14], page_index[31:26]
   input wire logic [31:0] req_tdata,
   input wire logic req_tvalid,
   output logic req_tready,
   // status[1:0], phys_page[13:2], found_valid[14], mapped_logical[26:15],
   // relocated_pages[38:27], blocks_cleaned[50:39], zero fill[55:51]
   output logic [55:0] rsp_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic csr_we,
   input wire logic [1:0] csr_index,
   input wire logic [12:0] csr_wdata
);
   import lfc_pkg::*;

   typedef enum logic [4:0] {
      ST_BUILD, ST_IDLE, ST_WCHK, ST_FREE, ST_CRD, ST_CCHK, ST_CADV,
      ST_PRD, ST_PINV, ST_PWR, ST_LCHK, ST_LADR, ST_LGET,
      ST_FM1, ST_FM2, ST_FCHK, ST_DONE
   } state_type;

   state_type state_ff;

   // csr shadow registers
   logic [12:0] reg_total_ff;
   logic [11:0] reg_user_ff;
   logic [6:0] reg_ppb_ff;

   // active geometry
   logic [12:0] geo_blocks_ff;
   logic [6:0] geo_ppb_ff;
   logic [12:0] geo_pages_ff;
   logic [12:0] geo_user_ff;

   // log pointers
   logic [11:0] head_ff;
   logic [11:0] tail_ff;

   // working registers
   logic [12:0] idx_ff;
   logic [6:0] pidx_ff;
   logic [12:0] cleaned_ff;
   logic [12:0] reloc_ff;
   logic [11:0] place_ff;
   logic host_ff;
   logic build_rsp_ff;
   logic [19:0] tp_ff;
   logic [11:0] lp_ff;
   logic [11:0] blk_ff;
   logic [5:0] pg_ff;

   // result fields
   logic [1:0] status_ff;
   logic [11:0] phys_ff;
   logic found_ff;
   logic [11:0] mapped_ff;

   logic rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   map_cmd_type map_cmd;
   logic [12:0] p2l_rd;
   logic [11:0] l2p_rd;
   logic [12:0] mac_a;
   logic [6:0] mac_b;
   logic [6:0] mac_c;
   logic [19:0] mac_res;

   logic [12:0] free_pages;
   logic [12:0] head_inc;
   logic [12:0] tail_inc;
   logic [11:0] head_next;
   logic [11:0] tail_next;
   logic geo_ok;
   logic req_beat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // free space between head and tail, modulo the log size
   always_comb begin
      if (tail_ff >= head_ff) begin
         free_pages = 13'(tail_ff) - 13'(head_ff);
      end else begin
         free_pages = 13'(tail_ff) + geo_pages_ff - 13'(head_ff);
      end
   end

   assign head_inc = 13'(head_ff) + 13'd1;
   assign tail_inc = 13'(tail_ff) + 13'd1;
   assign head_next = (head_inc == geo_pages_ff) ? 12'd0 : head_inc[11:0];
   assign tail_next = (tail_inc == geo_pages_ff) ? 12'd0 : tail_inc[11:0];

   assign geo_ok = (reg_ppb_ff != 7'd0) && (reg_ppb_ff <= MAX_PAGES_PER_BLOCK)
      && (reg_total_ff >= 13'd4) && (reg_user_ff != 12'd0)
      && ((13'(reg_user_ff) + 13'd3) <= reg_total_ff)
      && (tp_ff <= 20'(MAX_PHYS_PAGES));

   // shared multiply-add operand select
   always_comb begin
      mac_a = 13'(blk_ff);
      mac_b = geo_ppb_ff;
      mac_c = 7'(pg_ff);
      unique case (state_ff)
         ST_FM1: begin
            mac_a = reg_total_ff;
            mac_b = reg_ppb_ff;
            mac_c = 7'd0;
         end
         ST_FM2: begin
            mac_a = 13'(reg_user_ff);
            mac_b = reg_ppb_ff;
            mac_c = 7'd0;
         end
         default: begin
         end
      endcase
   end

   // map memory access per state
   always_comb begin
      map_cmd = '0;
      map_cmd.p2l_raddr = tail_ff;
      map_cmd.l2p_raddr = place_ff;
      unique case (state_ff)
         ST_BUILD: begin
            map_cmd.p2l_we = 1'b1;
            map_cmd.p2l_waddr = idx_ff[PHYS_AW-1:0];
            map_cmd.p2l_wdata = (idx_ff < geo_user_ff) ? idx_ff : P2L_INVALID;
            map_cmd.l2p_we = (idx_ff < geo_user_ff);
            map_cmd.l2p_waddr = idx_ff[PHYS_AW-1:0];
            map_cmd.l2p_wdata = idx_ff[11:0];
         end
         ST_LADR: begin
            map_cmd.p2l_raddr = mac_res[PHYS_AW-1:0];
         end
         ST_PINV: begin
            // old home of the page goes invalid
            map_cmd.p2l_we = (13'(l2p_rd) < geo_pages_ff);
            map_cmd.p2l_waddr = l2p_rd;
            map_cmd.p2l_wdata = P2L_INVALID;
         end
         ST_PWR: begin
            map_cmd.p2l_we = 1'b1;
            map_cmd.p2l_waddr = head_ff;
            map_cmd.p2l_wdata = 13'(place_ff);
            map_cmd.l2p_we = 1'b1;
            map_cmd.l2p_waddr = place_ff;
            map_cmd.l2p_wdata = head_ff;
         end
         default: begin
         end
      endcase
   end

   lfc_maps u_maps (
      .clock(clock),
      .cmd(map_cmd),
      .p2l_rd_ff(p2l_rd),
      .l2p_rd_ff(l2p_rd)
   );

   lfc_mac u_mac (
      .clock(clock),
      .mul_a(mac_a),
      .mul_b(mac_b),
      .add_c(mac_c),
      .res_ff(mac_res)
   );

   // csr shadow registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_total_ff <= RST_TOTAL_BLOCKS;
         reg_user_ff <= RST_USER_BLOCKS;
         reg_ppb_ff <= RST_PAGES_PER_BLOCK;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_BLOCKS: reg_total_ff <= csr_wdata;
            CSR_USER_BLOCKS: reg_user_ff <= csr_wdata[11:0];
            CSR_PAGES_PER_BLOCK: reg_ppb_ff <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BUILD;
         geo_blocks_ff <= RST_TOTAL_BLOCKS;
         geo_ppb_ff <= RST_PAGES_PER_BLOCK;
         geo_pages_ff <= 13'(RST_TOTAL_BLOCKS * 13'(RST_PAGES_PER_BLOCK));
         geo_user_ff <= 13'(13'(RST_USER_BLOCKS) * 13'(RST_PAGES_PER_BLOCK));
         head_ff <= 12'(13'(RST_USER_BLOCKS) * 13'(RST_PAGES_PER_BLOCK));
         tail_ff <= '0;
         idx_ff <= '0;
         build_rsp_ff <= 1'b0;
         cleaned_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state loads the next beat itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_BUILD: begin
               if (idx_ff == geo_pages_ff - 13'd1) begin
                  state_ff <= build_rsp_ff ? ST_DONE : ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 13'd1;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  lp_ff <= req_tdata[13:2];
                  blk_ff <= req_tdata[25:14];
                  pg_ff <= req_tdata[31:26];
                  status_ff <= STS_OK;
                  phys_ff <= '0;
                  found_ff <= 1'b0;
                  mapped_ff <= '0;
                  reloc_ff <= '0;
                  cleaned_ff <= '0;
                  unique case (req_tdata[1:0])
                     CMD_WRITE: state_ff <= ST_WCHK;
                     CMD_LOOKUP: state_ff <= ST_LCHK;
                     CMD_FORMAT: state_ff <= ST_FM1;
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_WCHK: begin
               if (13'(lp_ff) >= geo_user_ff) begin
                  status_ff <= STS_LPAGE_RANGE;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_FREE;
               end
            end
            ST_FREE: begin
               if (free_pages >= 13'({geo_ppb_ff, 1'b0}) || cleaned_ff >= geo_blocks_ff) begin
                  place_ff <= lp_ff;
                  host_ff <= 1'b1;
                  state_ff <= ST_PRD;
               end else begin
                  pidx_ff <= '0;
                  state_ff <= ST_CRD;
               end
            end
            ST_CRD: begin
               state_ff <= ST_CCHK;
            end
            ST_CCHK: begin
               if (p2l_rd != P2L_INVALID) begin
                  place_ff <= p2l_rd[11:0];
                  host_ff <= 1'b0;
                  reloc_ff <= reloc_ff + 13'd1;
                  state_ff <= ST_PRD;
               end else begin
                  state_ff <= ST_CADV;
               end
            end
            ST_CADV: begin
               tail_ff <= tail_next;
               if (pidx_ff + 7'd1 == geo_ppb_ff) begin
                  cleaned_ff <= cleaned_ff + 13'd1;
                  state_ff <= ST_FREE;
               end else begin
                  pidx_ff <= pidx_ff + 7'd1;
                  state_ff <= ST_CRD;
               end
            end
            ST_PRD: begin
               state_ff <= ST_PINV;
            end
            ST_PINV: begin
               state_ff <= ST_PWR;
            end
            ST_PWR: begin
               head_ff <= head_next;
               if (host_ff) begin
                  phys_ff <= head_ff;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_CADV;
               end
            end
            ST_LCHK: begin
               if (13'(blk_ff) >= geo_blocks_ff || 7'(pg_ff) >= geo_ppb_ff) begin
                  status_ff <= STS_LOOKUP_RANGE;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_LADR;
               end
            end
            ST_LADR: begin
               state_ff <= ST_LGET;
            end
            ST_LGET: begin
               if (p2l_rd != P2L_INVALID) begin
                  found_ff <= 1'b1;
                  mapped_ff <= p2l_rd[11:0];
               end
               state_ff <= ST_DONE;
            end
            ST_FM1: begin
               state_ff <= ST_FM2;
            end
            ST_FM2: begin
               tp_ff <= mac_res;
               state_ff <= ST_FCHK;
            end
            ST_FCHK: begin
               if (geo_ok) begin
                  geo_blocks_ff <= reg_total_ff;
                  geo_ppb_ff <= reg_ppb_ff;
                  geo_pages_ff <= tp_ff[12:0];
                  geo_user_ff <= mac_res[12:0];
                  head_ff <= mac_res[11:0];
                  tail_ff <= '0;
                  idx_ff <= '0;
                  build_rsp_ff <= 1'b1;
                  state_ff <= ST_BUILD;
               end else begin
                  status_ff <= STS_BAD_CONFIG;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {5'd0, cleaned_ff[11:0], reloc_ff[11:0], mapped_ff,
                                  found_ff, phys_ff, status_ff};
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`include "log_ftl_fifo_cleaner_core_assert.svh"

   `LFC_ASSERT_NOW(a_ptr_range, clock, reset, 1'b1, (13'(head_ff) < geo_pages_ff) && (13'(tail_ff) < geo_pages_ff))
   `LFC_ASSERT_NXT(a_busy_after_beat, clock, reset, req_beat, !req_tready)
   `LFC_ASSERT_NOW(a_clean_bound, clock, reset, state_ff == ST_FREE, cleaned_ff <= geo_blocks_ff)

endmodule
`default_nettype wire
